// ===== design/srfc_pkg.sv =====
// Shared types and constants for the servo response frame checker.
package srfc_pkg;

	localparam int unsigned CountW    = 5;
	localparam int unsigned PayloadN  = 15;
	localparam int unsigned PayloadAw = 4;

	localparam logic [CountW-1:0] COUNT_MAX     = 5'd31;
	localparam logic [CountW-1:0] POS_HDR0      = 5'd0;
	localparam logic [CountW-1:0] POS_HDR1      = 5'd1;
	localparam logic [CountW-1:0] POS_CMD       = 5'd2;
	localparam logic [CountW-1:0] POS_SIZE      = 5'd3;
	localparam logic [CountW-1:0] POS_ID        = 5'd4;
	localparam logic [CountW-1:0] POS_PAYLOAD   = 5'd5;
	localparam logic [CountW-1:0] POS_PAY_END   = 5'd20;

	localparam logic [CountW-1:0] LEN_MIN       = 5'd5;
	localparam logic [CountW-1:0] LEN_PING      = 5'd6;
	localparam logic [CountW-1:0] LEN_ANGLE     = 5'd8;
	localparam logic [CountW-1:0] LEN_TELEM     = 5'd21;

	localparam logic [7:0] HDR0       = 8'h05;
	localparam logic [7:0] HDR1       = 8'h1C;
	localparam logic [7:0] CMD_PING   = 8'd1;
	localparam logic [7:0] CMD_ANGLE  = 8'd10;
	localparam logic [7:0] CMD_TELEM  = 8'd22;
	localparam logic [7:0] SIZE_PING  = 8'd1;
	localparam logic [7:0] SIZE_ANGLE = 8'd3;
	localparam logic [7:0] SIZE_TELEM = 8'd16;

	typedef enum logic [2:0] {
		VERDICT_OK         = 3'd0,
		VERDICT_BAD_FRAME  = 3'd1,
		VERDICT_BAD_HEADER = 3'd2,
		VERDICT_BAD_SIZE   = 3'd3,
		VERDICT_BAD_ID     = 3'd4,
		VERDICT_BAD_SUM    = 3'd5
	} verdict_t;

	typedef enum logic [1:0] {
		OP_PING      = 2'd0,
		OP_ANGLE     = 2'd1,
		OP_TELEMETRY = 2'd2,
		OP_UNUSED    = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
		logic [7:0] expected_id;
		opcode_t    opcode;
	} item_t;

	typedef struct packed {
		verdict_t           verdict;
		logic [7:0]         reply_id;
		logic signed [15:0] supply_volt;
		logic signed [15:0] load_amp;
		logic signed [15:0] load_watt;
		logic signed [15:0] temp_code;
		logic [7:0]         servo_status;
		logic signed [31:0] angle_tenths;
		logic signed [15:0] turn_count;
	} result_t;

endpackage

// ===== design/srfc_in_reg.sv =====
// Input register stage: holds one accepted word until the core takes it.
module srfc_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,
	input  logic              s_tlast,
	input  logic [1:0]        s_tuser,
	input  logic              advance,
	output logic              valid_s1,
	output srfc_pkg::item_t   item_s1
);

	logic valid_q;

	assign s_tready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.rx_byte     <= s_tdata[7:0];
			item_s1.expected_id <= s_tdata[15:8];
			item_s1.frame_end   <= s_tlast;
			item_s1.opcode      <= srfc_pkg::opcode_t'(s_tuser);
		end
	end

endmodule

// ===== design/srfc_frame.sv =====
// Frame state (count, sum, captured bytes) and the verdict and field decode.
module srfc_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  srfc_pkg::item_t   item_s1,
	output srfc_pkg::result_t res
);

	logic [srfc_pkg::CountW-1:0] count_q;
	logic [7:0]                  sum_q;
	logic                        hdr_ok_q;
	logic [7:0]                  cmd_q;
	logic [7:0]                  size_q;
	logic [7:0]                  id_q;
	logic [7:0]                  payload_q [srfc_pkg::PayloadN];

	logic [srfc_pkg::CountW-1:0]   len;
	logic [srfc_pkg::CountW-1:0]   pay_off;
	logic [srfc_pkg::PayloadAw-1:0] pay_idx;
	logic                          pay_wr;
	srfc_pkg::verdict_t            verdict;

	assign len     = (count_q == srfc_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;
	assign pay_off = count_q - srfc_pkg::POS_PAYLOAD;
	assign pay_idx = pay_off[srfc_pkg::PayloadAw-1:0];
	assign pay_wr  = advance && !item_s1.frame_end && count_q >= srfc_pkg::POS_PAYLOAD
		&& count_q < srfc_pkg::POS_PAY_END;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_q    <= '0;
			hdr_ok_q <= 1'b0;
			cmd_q    <= '0;
			size_q   <= '0;
			id_q     <= '0;
		end else if (advance) begin
			if (item_s1.frame_end) begin
				count_q  <= '0;
				sum_q    <= '0;
				hdr_ok_q <= 1'b0;
			end else begin
				case (count_q)
					srfc_pkg::POS_HDR0: hdr_ok_q <= (item_s1.rx_byte == srfc_pkg::HDR0);
					srfc_pkg::POS_HDR1: hdr_ok_q <= hdr_ok_q
						&& (item_s1.rx_byte == srfc_pkg::HDR1);
					srfc_pkg::POS_CMD:  cmd_q  <= item_s1.rx_byte;
					srfc_pkg::POS_SIZE: size_q <= item_s1.rx_byte;
					srfc_pkg::POS_ID:   id_q   <= item_s1.rx_byte;
					default: ;
				endcase
				sum_q <= sum_q + item_s1.rx_byte;
				if (count_q != srfc_pkg::COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pay_wr) begin
			payload_q[pay_idx] <= item_s1.rx_byte;
		end
	end

	// check order: short frame, header, length/command/size (telemetry: command/size/length), id, checksum
	always_comb begin
		verdict = srfc_pkg::VERDICT_OK;
		if (len < srfc_pkg::LEN_MIN) begin
			verdict = srfc_pkg::VERDICT_BAD_FRAME;
		end else if (!hdr_ok_q) begin
			verdict = srfc_pkg::VERDICT_BAD_HEADER;
		end else begin
			case (item_s1.opcode)
				srfc_pkg::OP_PING: begin
					if (len != srfc_pkg::LEN_PING)        verdict = srfc_pkg::VERDICT_BAD_SIZE;
					else if (cmd_q != srfc_pkg::CMD_PING)  verdict = srfc_pkg::VERDICT_BAD_FRAME;
					else if (size_q != srfc_pkg::SIZE_PING) verdict = srfc_pkg::VERDICT_BAD_SIZE;
				end
				srfc_pkg::OP_ANGLE: begin
					if (len != srfc_pkg::LEN_ANGLE)        verdict = srfc_pkg::VERDICT_BAD_SIZE;
					else if (cmd_q != srfc_pkg::CMD_ANGLE) verdict = srfc_pkg::VERDICT_BAD_FRAME;
					else if (size_q != srfc_pkg::SIZE_ANGLE) verdict = srfc_pkg::VERDICT_BAD_SIZE;
				end
				srfc_pkg::OP_TELEMETRY: begin
					if (cmd_q != srfc_pkg::CMD_TELEM)        verdict = srfc_pkg::VERDICT_BAD_FRAME;
					else if (size_q != srfc_pkg::SIZE_TELEM) verdict = srfc_pkg::VERDICT_BAD_SIZE;
					else if (len != srfc_pkg::LEN_TELEM)     verdict = srfc_pkg::VERDICT_BAD_SIZE;
				end
				default: verdict = srfc_pkg::VERDICT_BAD_FRAME;
			endcase
			if (verdict == srfc_pkg::VERDICT_OK) begin
				if (id_q != item_s1.expected_id) begin
					verdict = srfc_pkg::VERDICT_BAD_ID;
				end else if (sum_q != item_s1.rx_byte) begin
					verdict = srfc_pkg::VERDICT_BAD_SUM;
				end
			end
		end
	end

	// decode little-endian fields; zero unless the frame passed
	always_comb begin
		res         = '0;
		res.verdict = verdict;
		if (verdict == srfc_pkg::VERDICT_OK) begin
			res.reply_id = id_q;
			case (item_s1.opcode)
				srfc_pkg::OP_ANGLE: begin
					res.angle_tenths = {{16{payload_q[1][7]}}, payload_q[1], payload_q[0]};
				end
				srfc_pkg::OP_TELEMETRY: begin
					res.supply_volt  = {payload_q[1], payload_q[0]};
					res.load_amp     = {payload_q[3], payload_q[2]};
					res.load_watt    = {payload_q[5], payload_q[4]};
					res.temp_code    = {payload_q[7], payload_q[6]};
					res.servo_status = payload_q[8];
					res.angle_tenths = {payload_q[12], payload_q[11], payload_q[10], payload_q[9]};
					res.turn_count   = {payload_q[14], payload_q[13]};
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.frame_end |=> count_q == '0 && sum_q == '0 && !hdr_ok_q)
		else $error("frame state not cleared after last byte");
	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !item_s1.frame_end && count_q != srfc_pkg::COUNT_MAX
		|=> count_q == $past(count_q) + 1'b1)
		else $error("byte count did not advance");
	a_hdr_needs_len: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_ok_q |-> count_q >= srfc_pkg::POS_HDR1)
		else $error("header match set before the first byte");
`endif

endmodule

// ===== design/servo_response_frame_checker_top.sv =====
// Top level of the servo response frame checker: input stage, frame core, result register.
// Takes one reply byte per word and gives one result word on the frame's last byte.
// An accepted word is registered in the input register, then checked and decoded
// into the result register once the core takes it. One word is taken every cycle; the
// input stalls only while a last byte waits in the input register behind a result
// word that m_tready has not yet taken.
// The verdict order is short frame, header, reply length/command/size (for telemetry
// command/size/length), id, then sum-of-bytes checksum; all decoded fields are zero
// unless the verdict is ok. Angle is in signed 0.1 degree.
module servo_response_frame_checker_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // rx_byte[7:0], expected_id[15:8]
	input  logic         s_tlast,   // frame_end
	input  logic [1:0]   s_tuser,   // opcode[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // reply_id[7:0], supply_volt[23:8], load_amp[39:24],
	                                // load_watt[55:40], temp_code[71:56], servo_status[79:72],
	                                // angle_tenths[111:80], turn_count[127:112]
	output logic [2:0]   m_tuser    // verdict[2:0]
);

	logic              valid_s1;
	logic              advance;
	srfc_pkg::item_t   item_s1;
	srfc_pkg::result_t res;
	srfc_pkg::result_t res_q;
	logic              m_valid_q;

	// non-final bytes never need the result register
	assign advance = valid_s1 && (!item_s1.frame_end || !m_valid_q || m_tready);

	srfc_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	srfc_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && item_s1.frame_end) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.frame_end) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.verdict;
	assign m_tdata  = {res_q.turn_count, res_q.angle_tenths, res_q.servo_status,
		res_q.temp_code, res_q.load_watt, res_q.load_amp, res_q.supply_volt, res_q.reply_id};

`ifndef SYNTHESIS
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != srfc_pkg::VERDICT_OK |-> m_tdata == '0)
		else $error("data fields not zero on failed frame");
	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= srfc_pkg::VERDICT_BAD_SUM)
		else $error("verdict code out of range");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.frame_end && m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while a final byte is blocked");
`endif

endmodule
